// File: hdl/pbaa_pkg.sv
// ============================================================================
// pbaa_pkg - shared types and constants of the paged bump allocator
// Field widths, register indexes, slot and result codes, and the command and
// status structs that join the controller to the datapath.
// ============================================================================
package pbaa_pkg;

   localparam int unsigned PAGE_SLOTS_DEFAULT = 16;

   // payload field widths
   localparam int unsigned BYTES_W  = 32;
   localparam int unsigned ALIGN_W  = 5;
   localparam int unsigned GEN_W    = 32;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned SLOT_W   = 4;
   localparam int unsigned COUNT_W  = 5;

   // configuration port
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned SIZE_W     = 32;
   localparam int unsigned TIMEOUT_W  = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_PAGE_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REUSE_TIMEOUT     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_TIMEOUT   = 2'd2;

   localparam logic [SIZE_W-1:0]    DEFAULT_PAGE_SIZE_RESET = 32'd4194304;
   localparam logic [TIMEOUT_W-1:0] REUSE_TIMEOUT_RESET     = 16'd8;
   localparam logic [TIMEOUT_W-1:0] RELEASE_TIMEOUT_RESET   = 16'd60;

   // command codes
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_GEN   = 1'b1;

   typedef enum logic [1:0] {
      SLOT_EMPTY = 2'd0,
      SLOT_USED  = 2'd1,
      SLOT_FREE  = 2'd2
   } slot_state_type;

   typedef enum logic [STATUS_W-1:0] {
      RSP_CURRENT = 2'd0,
      RSP_POOL    = 2'd1,
      RSP_FRESH   = 2'd2,
      RSP_NONE    = 2'd3
   } rsp_status_type;

   // controller to datapath
   typedef struct packed {
      logic idle;
      logic accept;
      logic a_prep;
      logic a_fit;
      logic scan_clear;
      logic scan_alloc;
      logic scan_gen;
      logic a_commit;
      logic g_prep1;
      logic g_prep2;
      logic g_final;
   } ctrl_type;

   // datapath to controller
   typedef struct packed {
      logic fit_hit;
      logic scan_done;
      logic out_free;
   } stat_type;

endpackage

// File: hdl/pbaa_req_if.sv
// ============================================================================
// pbaa_req_if - command channel of the paged bump allocator
// Valid/ready channel carrying one allocate or begin-generation command.
// ============================================================================
interface pbaa_req_if;

   logic                           valid;
   logic                           ready;
   logic                           command;
   logic [pbaa_pkg::BYTES_W-1:0]   request_bytes;
   logic [pbaa_pkg::ALIGN_W-1:0]   align_log2;
   logic [pbaa_pkg::GEN_W-1:0]     new_generation;

   modport source (
      output valid, command, request_bytes, align_log2, new_generation,
      input  ready
   );

   modport sink (
      input  valid, command, request_bytes, align_log2, new_generation,
      output ready
   );

endinterface

// File: hdl/pbaa_rsp_if.sv
// ============================================================================
// pbaa_rsp_if - result channel of the paged bump allocator
// Valid/ready channel carrying one result per command.
// ============================================================================
interface pbaa_rsp_if;

   logic                            valid;
   logic                            ready;
   logic [pbaa_pkg::STATUS_W-1:0]   status;
   logic [pbaa_pkg::SLOT_W-1:0]     page_slot;
   logic [pbaa_pkg::BYTES_W-1:0]    byte_offset;
   logic [pbaa_pkg::GEN_W-1:0]      alloc_generation;
   logic [pbaa_pkg::COUNT_W-1:0]    pages_freed;
   logic [pbaa_pkg::COUNT_W-1:0]    pages_deleted;

   modport source (
      output valid, status, page_slot, byte_offset, alloc_generation,
             pages_freed, pages_deleted,
      input  ready
   );

   modport sink (
      input  valid, status, page_slot, byte_offset, alloc_generation,
             pages_freed, pages_deleted,
      output ready
   );

endinterface

// File: hdl/pbaa_ctrl.sv
// ============================================================================
// pbaa_ctrl - sequencer of the paged bump allocator
// One-hot state machine stepping each command through prepare, slot scan
// (skipped on a fit) and commit; drives the datapath by command flags only.
// ============================================================================
module pbaa_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_command,
   input  pbaa_pkg::stat_type stat,
   output pbaa_pkg::ctrl_type ctrl
);

   typedef enum logic [8:0] {
      S_IDLE     = 9'b000000001,
      S_A_PREP   = 9'b000000010,
      S_A_FIT    = 9'b000000100,
      S_A_SCAN   = 9'b000001000,
      S_A_COMMIT = 9'b000010000,
      S_G_PREP1  = 9'b000100000,
      S_G_PREP2  = 9'b001000000,
      S_G_SCAN   = 9'b010000000,
      S_G_FINAL  = 9'b100000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      unique case (state_ff)
         S_IDLE: begin
            ctrl.idle = 1'b1;
            if (req_valid) begin
               ctrl.accept = 1'b1;
               state_in    = (req_command == pbaa_pkg::CMD_GEN) ? S_G_PREP1 : S_A_PREP;
            end
         end
         S_A_PREP: begin
            ctrl.a_prep = 1'b1;
            state_in    = S_A_FIT;
         end
         S_A_FIT: begin
            ctrl.a_fit      = 1'b1;
            ctrl.scan_clear = 1'b1;
            state_in        = stat.fit_hit ? S_A_COMMIT : S_A_SCAN;
         end
         S_A_SCAN: begin
            ctrl.scan_alloc = 1'b1;
            if (stat.scan_done) begin
               state_in = S_A_COMMIT;
            end
         end
         S_A_COMMIT: begin
            if (stat.out_free) begin
               ctrl.a_commit = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_G_PREP1: begin
            ctrl.g_prep1 = 1'b1;
            state_in     = S_G_PREP2;
         end
         S_G_PREP2: begin
            ctrl.g_prep2    = 1'b1;
            ctrl.scan_clear = 1'b1;
            state_in        = S_G_SCAN;
         end
         S_G_SCAN: begin
            ctrl.scan_gen = 1'b1;
            if (stat.scan_done) begin
               state_in = S_G_FINAL;
            end
         end
         S_G_FINAL: begin
            if (stat.out_free) begin
               ctrl.g_final = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hdl/pbaa_dpath.sv
// ============================================================================
// pbaa_dpath - datapath of the paged bump allocator
// Config registers, slot lanes (state and list rank), slot size and
// generation memories, scan pipeline, current-page registers and result
// register.
// ============================================================================
module pbaa_dpath #(
   parameter int unsigned PAGE_SLOTS = pbaa_pkg::PAGE_SLOTS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  pbaa_pkg::ctrl_type                  ctrl,
   output pbaa_pkg::stat_type                  stat,
   input  logic                                req_valid,
   input  logic [pbaa_pkg::BYTES_W-1:0]        req_request_bytes,
   input  logic [pbaa_pkg::ALIGN_W-1:0]        req_align_log2,
   input  logic [pbaa_pkg::GEN_W-1:0]          req_new_generation,
   input  logic                                csr_we,
   input  logic [pbaa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pbaa_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [pbaa_pkg::STATUS_W-1:0]       rsp_status,
   output logic [pbaa_pkg::SLOT_W-1:0]         rsp_page_slot,
   output logic [pbaa_pkg::BYTES_W-1:0]        rsp_byte_offset,
   output logic [pbaa_pkg::GEN_W-1:0]          rsp_alloc_generation,
   output logic [pbaa_pkg::COUNT_W-1:0]        rsp_pages_freed,
   output logic [pbaa_pkg::COUNT_W-1:0]        rsp_pages_deleted
);

   localparam int unsigned SW = (PAGE_SLOTS > 1) ? $clog2(PAGE_SLOTS) : 1;
   localparam int unsigned CW = $clog2(PAGE_SLOTS + 1);
   localparam logic [SW-1:0] LAST_SLOT = SW'(PAGE_SLOTS - 1);
   localparam logic [CW-1:0] SLOT_COUNT = CW'(PAGE_SLOTS);

   // configuration
   logic [pbaa_pkg::SIZE_W-1:0]    dps_ff;
   logic [pbaa_pkg::TIMEOUT_W-1:0] reuse_ff;
   logic [pbaa_pkg::TIMEOUT_W-1:0] release_ff;

   // captured command
   logic [pbaa_pkg::BYTES_W-1:0]   bytes_ff;
   logic [pbaa_pkg::ALIGN_W-1:0]   lg_ff;
   logic [pbaa_pkg::GEN_W-1:0]     newgen_ff;

   // allocate preparation
   logic [33:0] off_ff;
   logic [33:0] off_in;
   logic [32:0] asz_ff;
   logic [32:0] asz_in;
   logic [31:0] page_ff;
   logic [31:0] page_in;
   logic [31:0] mask_in;
   logic [34:0] fit_sum;
   logic        hit_ff;

   // aging thresholds, two's complement
   logic [33:0] thr1_ff;
   logic [33:0] thr2_ff;

   // scan pipeline
   logic [CW-1:0] cnt_ff;
   logic          ev_valid_ff;
   logic [SW-1:0] ev_idx_ff;
   logic          issue;
   logic [SW-1:0] rd_addr;

   // memories
   logic [31:0] size_mem [PAGE_SLOTS];
   logic [31:0] gen_mem  [PAGE_SLOTS];
   logic [31:0] size_rd_ff;
   logic [31:0] gen_rd_ff;
   logic        size_we;
   logic        gen_we;

   // lanes
   pbaa_pkg::slot_state_type status_ff [PAGE_SLOTS];
   pbaa_pkg::slot_state_type newst_ff  [PAGE_SLOTS];
   logic [SW-1:0]            rank_ff   [PAGE_SLOTS];
   logic [SW-1:0]            dec_ff    [PAGE_SLOTS];
   logic [SW-1:0]            up_ff     [PAGE_SLOTS];
   logic                     moved_ff  [PAGE_SLOTS];

   // list counts and generation tallies
   logic [CW-1:0] used_cnt_ff;
   logic [CW-1:0] free_cnt_ff;
   logic [CW-1:0] freed_ff;
   logic [CW-1:0] deleted_ff;
   logic [CW-1:0] del_old_ff;
   logic [CW-1:0] surv_ff;
   logic [CW-1:0] free_base;

   // pick trackers
   logic          best_valid_ff;
   logic [SW-1:0] best_idx_ff;
   logic [SW-1:0] best_rank_ff;
   logic          empty_found_ff;
   logic [SW-1:0] empty_idx_ff;

   // current page
   logic          cur_valid_ff;
   logic [SW-1:0] cur_slot_ff;
   logic [32:0]   cur_off_ff;
   logic [31:0]   cur_gen_ff;

   // result register
   logic                           rsp_valid_ff;
   pbaa_pkg::rsp_status_type       rsp_status_ff;
   logic [pbaa_pkg::SLOT_W-1:0]    rsp_slot_ff;
   logic [pbaa_pkg::BYTES_W-1:0]   rsp_off_ff;
   logic [pbaa_pkg::GEN_W-1:0]     rsp_gen_ff;
   logic [pbaa_pkg::COUNT_W-1:0]   rsp_freed_ff;
   logic [pbaa_pkg::COUNT_W-1:0]   rsp_deleted_ff;

   // scanned slot
   pbaa_pkg::slot_state_type st_k;
   logic [SW-1:0]            r_k;
   logic                     aged_k;
   logic                     del_k;
   logic                     gen_ev;
   logic                     alloc_ev;
   logic                     rm_used;
   logic                     surv_k;
   logic                     del_used;
   logic                     del_free;
   pbaa_pkg::slot_state_type newst_k;
   logic                     cand;
   logic                     emp;

   // commit selection
   pbaa_pkg::rsp_status_type kind;
   logic [SW-1:0]            pick;
   logic [33:0]              out_off;
   logic [32:0]              new_off;

   // ---------------------------------------------------------------------
   // allocate arithmetic
   // ---------------------------------------------------------------------
   assign mask_in = (32'd1 << lg_ff) - 32'd1;
   assign off_in  = ({1'b0, cur_off_ff} + {2'b0, mask_in}) & ~{2'b0, mask_in};
   assign asz_in  = ({1'b0, bytes_ff} + {1'b0, mask_in}) & ~{1'b0, mask_in};
   assign page_in = (bytes_ff > dps_ff) ? bytes_ff : dps_ff;
   assign fit_sum = {1'b0, off_ff} + {2'b0, asz_ff};

   assign stat.fit_hit   = cur_valid_ff && (fit_sum <= {3'b0, size_rd_ff});
   assign stat.scan_done = ev_valid_ff && (ev_idx_ff == LAST_SLOT);
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

   // ---------------------------------------------------------------------
   // scan pipeline: address issued one cycle, slot evaluated the next
   // ---------------------------------------------------------------------
   assign issue   = (ctrl.scan_alloc || ctrl.scan_gen) && (cnt_ff < SLOT_COUNT);
   assign rd_addr = ctrl.a_prep ? cur_slot_ff : cnt_ff[SW-1:0];

   assign st_k     = status_ff[ev_idx_ff];
   assign r_k      = rank_ff[ev_idx_ff];
   assign aged_k   = !thr1_ff[33] && (thr1_ff[31:0] > gen_rd_ff);
   assign del_k    = !thr2_ff[33] && (thr2_ff[31:0] > gen_rd_ff);
   assign gen_ev   = ctrl.scan_gen && ev_valid_ff;
   assign alloc_ev = ctrl.scan_alloc && ev_valid_ff;
   assign rm_used  = (st_k == pbaa_pkg::SLOT_USED) && aged_k;
   assign surv_k   = rm_used && !del_k;
   assign del_used = rm_used && del_k;
   assign del_free = (st_k == pbaa_pkg::SLOT_FREE) && del_k;
   assign cand     = (st_k == pbaa_pkg::SLOT_FREE) && (size_rd_ff == page_ff) &&
                     (!best_valid_ff || (r_k < best_rank_ff));
   assign emp      = (st_k == pbaa_pkg::SLOT_EMPTY) && !empty_found_ff;

   always_comb begin
      newst_k = st_k;
      if (rm_used) begin
         newst_k = del_k ? pbaa_pkg::SLOT_EMPTY : pbaa_pkg::SLOT_FREE;
      end else if (del_free) begin
         newst_k = pbaa_pkg::SLOT_EMPTY;
      end
   end

   // ---------------------------------------------------------------------
   // commit selection
   // ---------------------------------------------------------------------
   always_comb begin
      priority if (hit_ff) begin
         kind = pbaa_pkg::RSP_CURRENT;
         pick = cur_slot_ff;
      end else if (best_valid_ff) begin
         kind = pbaa_pkg::RSP_POOL;
         pick = best_idx_ff;
      end else if (empty_found_ff) begin
         kind = pbaa_pkg::RSP_FRESH;
         pick = empty_idx_ff;
      end else begin
         kind = pbaa_pkg::RSP_NONE;
         pick = empty_idx_ff;
      end
   end

   assign out_off   = (kind == pbaa_pkg::RSP_CURRENT) ? off_ff : 34'd0;
   assign new_off   = 33'(out_off + {2'b0, bytes_ff});
   assign size_we   = ctrl.a_commit && (kind == pbaa_pkg::RSP_FRESH);
   assign gen_we    = ctrl.a_commit && (kind != pbaa_pkg::RSP_NONE);
   assign free_base = free_cnt_ff - del_old_ff;

   // ---------------------------------------------------------------------
   // memories
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (size_we) begin
         size_mem[pick] <= page_ff;
      end
      size_rd_ff <= size_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (gen_we) begin
         gen_mem[pick] <= cur_gen_ff;
      end
      gen_rd_ff <= gen_mem[rd_addr];
   end

   // ---------------------------------------------------------------------
   // payload registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         bytes_ff  <= req_request_bytes;
         lg_ff     <= req_align_log2;
         newgen_ff <= req_new_generation;
      end
      if (ctrl.a_prep) begin
         off_ff  <= off_in;
         asz_ff  <= asz_in;
         page_ff <= page_in;
      end
      if (ctrl.a_fit) begin
         hit_ff <= stat.fit_hit;
      end
      if (ctrl.g_prep1) begin
         hit_ff  <= 1'b0;
         thr1_ff <= {2'b0, newgen_ff} - {18'b0, reuse_ff};
      end
      if (ctrl.g_prep2) begin
         thr2_ff <= thr1_ff - {18'b0, release_ff};
      end
      ev_idx_ff <= cnt_ff[SW-1:0];
      if (alloc_ev && cand) begin
         best_idx_ff  <= ev_idx_ff;
         best_rank_ff <= r_k;
      end
      if (alloc_ev && emp) begin
         empty_idx_ff <= ev_idx_ff;
      end
      if (ctrl.a_commit) begin
         rsp_status_ff  <= kind;
         rsp_freed_ff   <= '0;
         rsp_deleted_ff <= '0;
         if (kind == pbaa_pkg::RSP_NONE) begin
            rsp_slot_ff <= '0;
            rsp_off_ff  <= '0;
            rsp_gen_ff  <= '0;
         end else begin
            rsp_slot_ff <= pbaa_pkg::SLOT_W'(pick);
            rsp_off_ff  <= out_off[31:0];
            rsp_gen_ff  <= cur_gen_ff;
         end
      end
      if (ctrl.g_final) begin
         rsp_status_ff  <= pbaa_pkg::RSP_CURRENT;
         rsp_slot_ff    <= '0;
         rsp_off_ff     <= '0;
         rsp_gen_ff     <= '0;
         rsp_freed_ff   <= pbaa_pkg::COUNT_W'(freed_ff);
         rsp_deleted_ff <= pbaa_pkg::COUNT_W'(deleted_ff);
      end
   end

   // ---------------------------------------------------------------------
   // lanes: generation accumulators and rank
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      for (int s = 0; s < PAGE_SLOTS; s++) begin
         if (ctrl.scan_clear) begin
            dec_ff[s] <= '0;
            up_ff[s]  <= '0;
         end else if (gen_ev) begin
            // lower-ranked page leaving the same list closes the gap
            if (status_ff[s] == pbaa_pkg::SLOT_USED && rm_used && (r_k < rank_ff[s])) begin
               dec_ff[s] <= dec_ff[s] + SW'(1);
               if (surv_k) begin
                  up_ff[s] <= up_ff[s] + SW'(1);
               end
            end
            if (status_ff[s] == pbaa_pkg::SLOT_FREE && del_free && (r_k < rank_ff[s])) begin
               dec_ff[s] <= dec_ff[s] + SW'(1);
            end
            if (ev_idx_ff == SW'(s)) begin
               newst_ff[s] <= newst_k;
               moved_ff[s] <= surv_k;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < PAGE_SLOTS; s++) begin
         if (ctrl.a_commit) begin
            if (kind == pbaa_pkg::RSP_POOL && status_ff[s] == pbaa_pkg::SLOT_FREE &&
                rank_ff[s] > best_rank_ff) begin
               rank_ff[s] <= rank_ff[s] - SW'(1);
            end
            if ((kind == pbaa_pkg::RSP_POOL || kind == pbaa_pkg::RSP_FRESH) &&
                pick == SW'(s)) begin
               rank_ff[s] <= SW'(used_cnt_ff);
            end
         end else if (ctrl.g_final) begin
            // freed pages queue behind the surviving free pool
            if (moved_ff[s]) begin
               rank_ff[s] <= SW'(free_base + CW'(up_ff[s]));
            end else begin
               rank_ff[s] <= rank_ff[s] - dec_ff[s];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < PAGE_SLOTS; s++) begin
            status_ff[s] <= pbaa_pkg::SLOT_EMPTY;
         end
      end else begin
         for (int s = 0; s < PAGE_SLOTS; s++) begin
            if (ctrl.a_commit) begin
               if ((kind == pbaa_pkg::RSP_POOL || kind == pbaa_pkg::RSP_FRESH) &&
                   pick == SW'(s)) begin
                  status_ff[s] <= pbaa_pkg::SLOT_USED;
               end
            end else if (ctrl.g_final) begin
               status_ff[s] <= newst_ff[s];
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // control state
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         dps_ff         <= pbaa_pkg::DEFAULT_PAGE_SIZE_RESET;
         reuse_ff       <= pbaa_pkg::REUSE_TIMEOUT_RESET;
         release_ff     <= pbaa_pkg::RELEASE_TIMEOUT_RESET;
         cnt_ff         <= '0;
         ev_valid_ff    <= 1'b0;
         best_valid_ff  <= 1'b0;
         empty_found_ff <= 1'b0;
         used_cnt_ff    <= '0;
         free_cnt_ff    <= '0;
         freed_ff       <= '0;
         deleted_ff     <= '0;
         del_old_ff     <= '0;
         surv_ff        <= '0;
         cur_valid_ff   <= 1'b0;
         cur_slot_ff    <= '0;
         cur_off_ff     <= '0;
         cur_gen_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               pbaa_pkg::CSR_DEFAULT_PAGE_SIZE: dps_ff     <= csr_wdata;
               pbaa_pkg::CSR_REUSE_TIMEOUT:     reuse_ff   <= csr_wdata[15:0];
               pbaa_pkg::CSR_RELEASE_TIMEOUT:   release_ff <= csr_wdata[15:0];
               default: ;
            endcase
         end

         ev_valid_ff <= issue;
         if (ctrl.scan_clear) begin
            cnt_ff         <= '0;
            best_valid_ff  <= 1'b0;
            empty_found_ff <= 1'b0;
            freed_ff       <= '0;
            deleted_ff     <= '0;
            del_old_ff     <= '0;
            surv_ff        <= '0;
         end else if (issue) begin
            cnt_ff <= cnt_ff + CW'(1);
         end

         if (alloc_ev && cand) begin
            best_valid_ff <= 1'b1;
         end
         if (alloc_ev && emp) begin
            empty_found_ff <= 1'b1;
         end

         if (gen_ev) begin
            freed_ff   <= freed_ff + CW'(rm_used);
            deleted_ff <= deleted_ff + CW'(del_used || del_free);
            del_old_ff <= del_old_ff + CW'(del_free);
            surv_ff    <= surv_ff + CW'(surv_k);
            if (rm_used && ev_idx_ff == cur_slot_ff) begin
               cur_valid_ff <= 1'b0;
            end
         end

         // page no longer fits: drop it before the search
         if (ctrl.a_fit && !stat.fit_hit) begin
            cur_valid_ff <= 1'b0;
         end

         if (ctrl.a_commit && kind != pbaa_pkg::RSP_NONE) begin
            cur_valid_ff <= 1'b1;
            cur_slot_ff  <= pick;
            cur_off_ff   <= new_off;
            if (kind == pbaa_pkg::RSP_POOL) begin
               used_cnt_ff <= used_cnt_ff + CW'(1);
               free_cnt_ff <= free_cnt_ff - CW'(1);
            end else if (kind == pbaa_pkg::RSP_FRESH) begin
               used_cnt_ff <= used_cnt_ff + CW'(1);
            end
         end

         if (ctrl.g_final) begin
            used_cnt_ff <= used_cnt_ff - freed_ff;
            free_cnt_ff <= free_base + surv_ff;
            cur_gen_ff  <= newgen_ff;
         end

         if (ctrl.a_commit || ctrl.g_final) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_page_slot        = rsp_slot_ff;
   assign rsp_byte_offset      = rsp_off_ff;
   assign rsp_alloc_generation = rsp_gen_ff;
   assign rsp_pages_freed      = rsp_freed_ff;
   assign rsp_pages_deleted    = rsp_deleted_ff;

endmodule

// File: hdl/paged_bump_allocator_aging.sv
// ============================================================================
// paged_bump_allocator_aging - paged bump allocator with generation aging
// Top level: joins the command sequencer and the datapath to the channels
// and the configuration write port.
// ============================================================================
// One command is in work at a time; each gives exactly one result. An
// allocate that fits the current page goes from the fit check straight to
// commit. An allocate that must search, and every begin-generation command,
// walks the slot size and generation memories one slot per cycle through
// their single read port. A new command may be transferred while the
// previous result still waits on the result channel; only the final commit
// step waits for it. Slot state is held in flip-flops cleared by reset, so
// no clearing pass is needed. Configuration writes are taken on any cycle
// and should land only while the block is idle.
// ============================================================================
module paged_bump_allocator_aging #(
   parameter int unsigned PAGE_SLOTS = pbaa_pkg::PAGE_SLOTS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   pbaa_req_if.sink                          req_ch,
   pbaa_rsp_if.source                        rsp_ch,
   input  logic                              csr_we,
   input  logic [pbaa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pbaa_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   pbaa_pkg::ctrl_type ctrl;
   pbaa_pkg::stat_type stat;

   // command channel is ready only between commands
   assign req_ch.ready = ctrl.idle;

   // sequencer: prepare, scan one slot a cycle where a search is needed, commit
   pbaa_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_command (req_ch.command),
      .stat        (stat),
      .ctrl        (ctrl)
   );

   // slot lanes, memories, current page and the result register
   pbaa_dpath #(
      .PAGE_SLOTS (PAGE_SLOTS)
   ) u_dpath (
      .clock                (clock),
      .reset                (reset),
      .ctrl                 (ctrl),
      .stat                 (stat),
      .req_valid            (req_ch.valid),
      .req_request_bytes    (req_ch.request_bytes),
      .req_align_log2       (req_ch.align_log2),
      .req_new_generation   (req_ch.new_generation),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .rsp_ready            (rsp_ch.ready),
      .rsp_valid            (rsp_ch.valid),
      .rsp_status           (rsp_ch.status),
      .rsp_page_slot        (rsp_ch.page_slot),
      .rsp_byte_offset      (rsp_ch.byte_offset),
      .rsp_alloc_generation (rsp_ch.alloc_generation),
      .rsp_pages_freed      (rsp_ch.pages_freed),
      .rsp_pages_deleted    (rsp_ch.pages_deleted)
   );

endmodule
